>>> rtl/ple_pkg.sv
`timescale 1ns / 1ps

package ple_pkg;

  localparam int unsigned OpW  = 3;
  localparam int unsigned PosW = 5;

  // request codes
  localparam logic [OpW-1:0] OP_GET    = 3'd0;
  localparam logic [OpW-1:0] OP_INSERT = 3'd1;
  localparam logic [OpW-1:0] OP_DELETE = 3'd2;
  localparam logic [OpW-1:0] OP_SEARCH = 3'd3;
  localparam logic [OpW-1:0] OP_CLEAR  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_POS   = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // probe token walking down the chain
  typedef struct packed {
    logic valid;
    logic hit;
  } probe_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic [OpW-1:0]  op;
    logic [PosW-1:0] pos;
    logic            ins_commit;
    logic            del_commit;
  } cell_ctl_t;

endpackage

>>> rtl/positional_list_engine.sv
`timescale 1ns / 1ps

// Bounded ordered list of up to CAPACITY words, one word per cell in a chain.
// A request (get, insert, delete, search, clear) is taken on a clock edge with
// start high and busy low; its single result is shown on the result ports for
// exactly one cycle with done_o high, and the receiver cannot stall it, so it
// must take the word in that cycle. busy stays high from the accepting edge
// until done_o rises, so a new start can be taken on the edge on which the
// result is taken; the block works on one request at a time.
// The probe token walks the cell chain one cell per cycle to pick up the
// addressed word or the first match; the shift for insert and delete then
// happens in all cells at once on the final edge.
// Positions are 1-based. Status: ok, bad position, list full, not found.

module positional_list_engine #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [2:0]               op_i,
  input  logic [4:0]               position_i,
  input  logic signed [31:0]       value_in_i,
  output logic                     done_o,
  output logic [1:0]               status_o,
  output logic signed [31:0]       value_out_o,
  output logic [4:0]               found_index_o,
  output logic [4:0]               list_length_o,
  output logic                     is_empty_o
);

  localparam int unsigned LenW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);

  // chain wiring: entry k feeds cell k, entry CAPACITY leaves the last cell
  ple_pkg::probe_t        probe_w [CAPACITY+1];
  logic [DATA_WIDTH-1:0]  pword_w [CAPACITY+1];
  logic [IdxW-1:0]        pidx_w  [CAPACITY+1];
  logic [DATA_WIDTH-1:0]  word_w  [CAPACITY];

  ple_pkg::cell_ctl_t     ctl;
  logic [DATA_WIDTH-1:0]  val;
  logic [LenW-1:0]        len;

  ple_ctrl #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_o        (busy),
    .op_i          (op_i),
    .position_i    (position_i),
    .value_in_i    (value_in_i),
    .launch_o      (probe_w[0]),
    .ctl_o         (ctl),
    .val_o         (val),
    .len_o         (len),
    .probe_i       (probe_w[CAPACITY]),
    .pword_i       (pword_w[CAPACITY]),
    .pidx_i        (pidx_w[CAPACITY]),
    .done_o        (done_o),
    .status_o      (status_o),
    .value_out_o   (value_out_o),
    .found_index_o (found_index_o),
    .list_length_o (list_length_o),
    .is_empty_o    (is_empty_o)
  );

  // probe enters the chain carrying nothing
  assign pword_w[0] = '0;
  assign pidx_w[0]  = '0;

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_WIDTH-1:0] left_w, right_w;

    // head has no left neighbour and the tail no right one; those inputs
    // are never selected for any cell that holds a live word
    if (k == 0) begin : g_head
      assign left_w = val;
    end else begin : g_mid_l
      assign left_w = word_w[k-1];
    end
    if (k == CAPACITY - 1) begin : g_tail
      assign right_w = word_w[k];
    end else begin : g_mid_r
      assign right_w = word_w[k+1];
    end

    ple_cell #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH),
      .INDEX      (k)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctl_i        (ctl),
      .val_i        (val),
      .len_i        (len),
      .left_word_i  (left_w),
      .right_word_i (right_w),
      .word_o       (word_w[k]),
      .probe_i      (probe_w[k]),
      .pword_i      (pword_w[k]),
      .pidx_i       (pidx_w[k]),
      .probe_o      (probe_w[k+1]),
      .pword_o      (pword_w[k+1]),
      .pidx_o       (pidx_w[k+1])
    );
  end

endmodule

>>> rtl/ple_cell.sv
`timescale 1ns / 1ps

module ple_cell #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned INDEX      = 0
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ple_pkg::cell_ctl_t                  ctl_i,
  input  logic [DATA_WIDTH-1:0]               val_i,
  input  logic [$clog2(CAPACITY+1)-1:0]       len_i,
  input  logic [DATA_WIDTH-1:0]               left_word_i,
  input  logic [DATA_WIDTH-1:0]               right_word_i,
  output logic [DATA_WIDTH-1:0]               word_o,
  input  ple_pkg::probe_t                     probe_i,
  input  logic [DATA_WIDTH-1:0]               pword_i,
  input  logic [$clog2(CAPACITY)-1:0]         pidx_i,
  output ple_pkg::probe_t                     probe_o,
  output logic [DATA_WIDTH-1:0]               pword_o,
  output logic [$clog2(CAPACITY)-1:0]         pidx_o
);

  localparam int unsigned LenW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = ((LenW > ple_pkg::PosW) ? LenW : ple_pkg::PosW) + 1;

  logic [DATA_WIDTH-1:0] word_q, word_d;
  ple_pkg::probe_t       probe_q, probe_d;
  logic [DATA_WIDTH-1:0] pword_q, pword_d;
  logic [IdxW-1:0]       pidx_q, pidx_d;

  logic [CmpW-1:0] pos_ext;
  logic [CmpW-1:0] my_pos;   // 1-based place of this cell
  logic            rd_op;
  logic            sel;

  assign pos_ext = CmpW'(ctl_i.pos);
  assign my_pos  = CmpW'(INDEX + 1);
  assign rd_op   = (ctl_i.op == ple_pkg::OP_GET) || (ctl_i.op == ple_pkg::OP_DELETE);

  always_comb begin
    if (rd_op) begin
      sel = (my_pos == pos_ext);
    end else begin
      sel = (ctl_i.op == ple_pkg::OP_SEARCH) && (CmpW'(INDEX) < CmpW'(len_i)) &&
            (word_q == val_i);
    end
    sel = sel && probe_i.valid && !probe_i.hit;

    probe_d.valid = probe_i.valid;
    probe_d.hit   = probe_i.hit | sel;
    pword_d       = sel ? word_q : pword_i;
    pidx_d        = sel ? IdxW'(INDEX) : pidx_i;
  end

  // shift on commit: insert pulls from the left, delete from the right
  always_comb begin
    word_d = word_q;
    priority if (ctl_i.ins_commit) begin
      if (my_pos == pos_ext) begin
        word_d = val_i;
      end else if (my_pos > pos_ext) begin
        word_d = left_word_i;
      end
    end else if (ctl_i.del_commit) begin
      if (my_pos >= pos_ext) begin
        word_d = right_word_i;
      end
    end else begin
      word_d = word_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      probe_q <= '0;
    end else begin
      probe_q <= probe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q  <= word_d;
    pword_q <= pword_d;
    pidx_q  <= pidx_d;
  end

  assign word_o  = word_q;
  assign probe_o = probe_q;
  assign pword_o = pword_q;
  assign pidx_o  = pidx_q;

endmodule

>>> rtl/ple_ctrl.sv
`timescale 1ns / 1ps

module ple_ctrl #(
  parameter int unsigned CAPACITY   = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [ple_pkg::OpW-1:0]       op_i,
  input  logic [ple_pkg::PosW-1:0]      position_i,
  input  logic signed [31:0]            value_in_i,
  output ple_pkg::probe_t               launch_o,
  output ple_pkg::cell_ctl_t            ctl_o,
  output logic [DATA_WIDTH-1:0]         val_o,
  output logic [$clog2(CAPACITY+1)-1:0] len_o,
  input  ple_pkg::probe_t               probe_i,
  input  logic [DATA_WIDTH-1:0]         pword_i,
  input  logic [$clog2(CAPACITY)-1:0]   pidx_i,
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic signed [31:0]            value_out_o,
  output logic [4:0]                    found_index_o,
  output logic [4:0]                    list_length_o,
  output logic                          is_empty_o
);

  localparam int unsigned LenW = $clog2(CAPACITY + 1);
  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CmpW = ((LenW > ple_pkg::PosW) ? LenW : ple_pkg::PosW) + 1;

  logic                       busy_q, busy_d;
  logic                       launch_q;
  logic [ple_pkg::OpW-1:0]    op_q;
  logic [ple_pkg::PosW-1:0]   pos_q;
  logic [DATA_WIDTH-1:0]      val_q;
  logic [LenW-1:0]            len_q, len_d;
  logic                       done_q;
  logic [1:0]                 status_q, status_d;
  logic signed [31:0]         vout_q, vout_d;
  logic [4:0]                 fidx_q, fidx_d;

  logic            accept;
  logic            fin;
  logic            pos_zero;
  logic [CmpW-1:0] pos_ext, len_ext;
  logic            bad_rd, bad_ins, full;
  logic            ins_ok, del_ok;
  logic [IdxW:0]   idx_p1;

  assign accept   = start_i && !busy_q;
  assign fin      = probe_i.valid;
  assign pos_zero = (pos_q == '0);
  assign pos_ext  = CmpW'(pos_q);
  assign len_ext  = CmpW'(len_q);
  assign bad_rd   = pos_zero || (pos_ext > len_ext);
  assign bad_ins  = pos_zero || (pos_ext > (len_ext + CmpW'(1)));
  assign full     = (len_q == LenW'(CAPACITY));
  assign idx_p1   = {1'b0, pidx_i} + (IdxW+1)'(1);

  always_comb begin
    status_d = ple_pkg::ST_OK;
    vout_d   = '0;
    fidx_d   = '0;
    len_d    = len_q;
    ins_ok   = 1'b0;
    del_ok   = 1'b0;
    unique case (op_q)
      ple_pkg::OP_GET: begin
        if (bad_rd) begin
          status_d = ple_pkg::ST_BAD_POS;
        end else begin
          vout_d = 32'($signed(pword_i));
        end
      end
      ple_pkg::OP_INSERT: begin
        if (bad_ins) begin
          status_d = ple_pkg::ST_BAD_POS;
        end else if (full) begin
          status_d = ple_pkg::ST_FULL;
        end else begin
          ins_ok = 1'b1;
          len_d  = len_q + LenW'(1);
        end
      end
      ple_pkg::OP_DELETE: begin
        if (bad_rd) begin
          status_d = ple_pkg::ST_BAD_POS;
        end else begin
          vout_d = 32'($signed(pword_i));
          del_ok = 1'b1;
          len_d  = len_q - LenW'(1);
        end
      end
      ple_pkg::OP_SEARCH: begin
        if (probe_i.hit) begin
          fidx_d = 5'(idx_p1);
        end else begin
          status_d = ple_pkg::ST_NOT_FOUND;
        end
      end
      ple_pkg::OP_CLEAR: begin
        len_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (fin) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      launch_q <= 1'b0;
      done_q   <= 1'b0;
      len_q    <= '0;
    end else begin
      busy_q   <= busy_d;
      launch_q <= accept;
      done_q   <= fin;
      if (fin) begin
        len_q <= len_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      pos_q <= position_i;
      val_q <= DATA_WIDTH'(value_in_i);
    end
    if (fin) begin
      status_q <= status_d;
      vout_q   <= vout_d;
      fidx_q   <= fidx_d;
    end
  end

  assign busy_o          = busy_q;
  assign launch_o.valid  = launch_q;
  assign launch_o.hit    = 1'b0;
  assign ctl_o.op        = op_q;
  assign ctl_o.pos       = pos_q;
  assign ctl_o.ins_commit = fin && ins_ok;
  assign ctl_o.del_commit = fin && del_ok;
  assign val_o           = val_q;
  assign len_o           = len_q;

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign value_out_o   = vout_q;
  assign found_index_o = fidx_q;
  assign list_length_o = 5'(len_q);
  assign is_empty_o    = (len_q == '0);

endmodule
